// ===== hw/rtl/terminal_key_escape_decoder_defines.svh =====
// Assertion macros shared by the key escape decoder RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef TERMINAL_KEY_ESCAPE_DECODER_DEFINES_SVH
`define TERMINAL_KEY_ESCAPE_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TKED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TKED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tked_pkg.sv =====
// Package for the terminal key escape decoder: types, byte and key codes,
// and the key lookup functions. No dependencies.
`timescale 1ns / 1ps

package tked_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KeyW  = 9;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ESC     = 3'd1,
    PH_BRACKET = 3'd2,
    PH_OH      = 3'd3,
    PH_OTHER   = 3'd4,
    PH_DIGIT   = 3'd5
  } phase_e;

  localparam logic [ByteW-1:0] CH_ESC    = 8'h1B;
  localparam logic [ByteW-1:0] CH_LBRACK = 8'h5B;
  localparam logic [ByteW-1:0] CH_O      = 8'h4F;
  localparam logic [ByteW-1:0] CH_TILDE  = 8'h7E;
  localparam logic [ByteW-1:0] CH_0      = 8'h30;
  localparam logic [ByteW-1:0] CH_1      = 8'h31;
  localparam logic [ByteW-1:0] CH_3      = 8'h33;
  localparam logic [ByteW-1:0] CH_4      = 8'h34;
  localparam logic [ByteW-1:0] CH_5      = 8'h35;
  localparam logic [ByteW-1:0] CH_6      = 8'h36;
  localparam logic [ByteW-1:0] CH_7      = 8'h37;
  localparam logic [ByteW-1:0] CH_8      = 8'h38;
  localparam logic [ByteW-1:0] CH_9      = 8'h39;
  localparam logic [ByteW-1:0] CH_X      = 8'h78;
  localparam logic [ByteW-1:0] CH_LF     = 8'h66;
  localparam logic [ByteW-1:0] CH_LB     = 8'h62;
  localparam logic [ByteW-1:0] CH_UA     = 8'h41;
  localparam logic [ByteW-1:0] CH_UB     = 8'h42;
  localparam logic [ByteW-1:0] CH_UC     = 8'h43;
  localparam logic [ByteW-1:0] CH_UD     = 8'h44;
  localparam logic [ByteW-1:0] CH_UH     = 8'h48;
  localparam logic [ByteW-1:0] CH_UF     = 8'h46;
  localparam logic [ByteW-1:0] CH_CTRL_P = 8'h10;
  localparam logic [ByteW-1:0] CH_CTRL_N = 8'h0E;
  localparam logic [ByteW-1:0] CH_CTRL_F = 8'h06;
  localparam logic [ByteW-1:0] CH_CTRL_B = 8'h02;
  localparam logic [ByteW-1:0] CH_CTRL_A = 8'h01;
  localparam logic [ByteW-1:0] CH_CTRL_E = 8'h05;

  localparam logic [KeyW-1:0] KC_ESC   = 9'd27;
  localparam logic [KeyW-1:0] KC_LEFT  = 9'd256;
  localparam logic [KeyW-1:0] KC_RIGHT = 9'd257;
  localparam logic [KeyW-1:0] KC_UP    = 9'd258;
  localparam logic [KeyW-1:0] KC_DOWN  = 9'd259;
  localparam logic [KeyW-1:0] KC_DEL   = 9'd260;
  localparam logic [KeyW-1:0] KC_HOME  = 9'd261;
  localparam logic [KeyW-1:0] KC_END   = 9'd262;
  localparam logic [KeyW-1:0] KC_PGUP  = 9'd263;
  localparam logic [KeyW-1:0] KC_PGDN  = 9'd264;
  localparam logic [KeyW-1:0] KC_MX    = 9'd265;
  localparam logic [KeyW-1:0] KC_MF    = 9'd266;
  localparam logic [KeyW-1:0] KC_MB    = 9'd267;

  typedef struct packed {
    logic             valid;
    logic             opcode;
    logic [ByteW-1:0] rx_byte;
  } beat_t;

  typedef struct packed {
    logic            emit;
    logic [KeyW-1:0] key_code;
  } result_t;

  function automatic logic [KeyW-1:0] plain_key(input logic [ByteW-1:0] b);
    logic [KeyW-1:0] k;
    case (b)
      CH_CTRL_P: k = KC_UP;
      CH_CTRL_N: k = KC_DOWN;
      CH_CTRL_F: k = KC_RIGHT;
      CH_CTRL_B: k = KC_LEFT;
      CH_CTRL_A: k = KC_HOME;
      CH_CTRL_E: k = KC_END;
      default:   k = {1'b0, b};
    endcase
    return k;
  endfunction

  function automatic logic [KeyW-1:0] bracket_letter(input logic [ByteW-1:0] b);
    logic [KeyW-1:0] k;
    case (b)
      CH_UA:   k = KC_UP;
      CH_UB:   k = KC_DOWN;
      CH_UC:   k = KC_RIGHT;
      CH_UD:   k = KC_LEFT;
      CH_UH:   k = KC_HOME;
      CH_UF:   k = KC_END;
      default: k = KC_ESC;
    endcase
    return k;
  endfunction

  function automatic logic [KeyW-1:0] tilde_digit(input logic [ByteW-1:0] d);
    logic [KeyW-1:0] k;
    case (d)
      CH_1:    k = KC_HOME;
      CH_3:    k = KC_DEL;
      CH_4:    k = KC_END;
      CH_5:    k = KC_PGUP;
      CH_6:    k = KC_PGDN;
      CH_7:    k = KC_HOME;
      CH_8:    k = KC_END;
      default: k = KC_ESC;
    endcase
    return k;
  endfunction

endpackage

// ===== hw/rtl/tked_byte_if.sv =====
// Input channel of the key escape decoder: opcode and received byte.
// Depends on nothing.
`timescale 1ns / 1ps

interface tked_byte_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

// ===== hw/rtl/tked_key_if.sv =====
// Output channel of the key escape decoder: one key code per beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface tked_key_if;
  logic       valid;
  logic       ready;
  logic [8:0] key_code;

  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

// ===== hw/rtl/tked_in_reg.sv =====
// Input register of the key escape decoder: captures one input beat.
// Depends on tked_pkg and tked_byte_if.
`timescale 1ns / 1ps

module tked_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  tked_byte_if.sink       byte_in_i,
  input  logic            advance_i,
  output tked_pkg::beat_t beat_o
);
  import tked_pkg::*;

  logic             valid_q, valid_d;
  logic             opcode_q;
  logic [ByteW-1:0] byte_q;
  logic             take;

  assign byte_in_i.ready = !valid_q || advance_i;
  assign take            = byte_in_i.valid && byte_in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (byte_in_i.ready) begin
      valid_d = byte_in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      opcode_q <= byte_in_i.opcode;
      byte_q   <= byte_in_i.rx_byte;
    end
  end

  assign beat_o = '{valid: valid_q, opcode: opcode_q, rx_byte: byte_q};
endmodule

// ===== hw/rtl/tked_parse.sv =====
// Escape sequence parser: phase and held digit registers plus the key decode.
// Depends on tked_pkg and terminal_key_escape_decoder_defines.svh.
`timescale 1ns / 1ps

`include "terminal_key_escape_decoder_defines.svh"

module tked_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tked_pkg::beat_t   beat_i,
  output tked_pkg::result_t result_o
);
  import tked_pkg::*;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] digit_q, digit_d;
  logic             tick;
  logic [ByteW-1:0] b;
  logic             in_seq;

  assign tick   = beat_i.opcode;
  assign b      = beat_i.rx_byte;
  assign in_seq = phase_q inside {PH_ESC, PH_BRACKET, PH_OH, PH_OTHER, PH_DIGIT};

  always_comb begin
    phase_d  = phase_q;
    digit_d  = digit_q;
    result_o = '0;
    if (beat_i.valid) begin
      if (!in_seq) begin
        if (!tick) begin
          if (b == CH_ESC) begin
            phase_d = PH_ESC;
          end else begin
            phase_d  = PH_IDLE;
            result_o = '{emit: 1'b1, key_code: plain_key(b)};
          end
        end
      end else if (tick) begin
        phase_d  = PH_IDLE;
        result_o = '{emit: 1'b1, key_code: KC_ESC};
      end else begin
        phase_d  = PH_IDLE;
        result_o = '{emit: 1'b1, key_code: KC_ESC};
        case (phase_q)
          PH_ESC: begin
            if (b == CH_X) begin
              result_o.key_code = KC_MX;
            end else if (b == CH_LF) begin
              result_o.key_code = KC_MF;
            end else if (b == CH_LB) begin
              result_o.key_code = KC_MB;
            end else begin
              result_o.emit = 1'b0;
              if (b == CH_LBRACK) begin
                phase_d = PH_BRACKET;
              end else if (b == CH_O) begin
                phase_d = PH_OH;
              end else begin
                phase_d = PH_OTHER;
              end
            end
          end
          PH_BRACKET: begin
            if (b >= CH_0 && b <= CH_9) begin
              digit_d       = b;
              phase_d       = PH_DIGIT;
              result_o.emit = 1'b0;
            end else begin
              result_o.key_code = bracket_letter(b);
            end
          end
          PH_OH: begin
            if (b == CH_UH) begin
              result_o.key_code = KC_HOME;
            end else if (b == CH_UF) begin
              result_o.key_code = KC_END;
            end
          end
          PH_DIGIT: begin
            if (b == CH_TILDE) begin
              result_o.key_code = tilde_digit(digit_q);
            end
          end
          default: begin
            result_o.key_code = KC_ESC;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      digit_q <= '0;
    end else begin
      phase_q <= phase_d;
      digit_q <= digit_d;
    end
  end

  `TKED_ASSERT_NEXT(a_tick_ends_seq, beat_i.valid && beat_i.opcode, phase_q == PH_IDLE, "tick left a sequence open")
  `TKED_ASSERT_NOW(a_digit_held, phase_q == PH_DIGIT, digit_q >= CH_0 && digit_q <= CH_9, "digit phase without a digit")
  `TKED_ASSERT_NOW(a_tick_idle_silent, beat_i.valid && beat_i.opcode && !in_seq, !result_o.emit, "key emitted on idle tick")
  `TKED_ASSERT_NEXT(a_esc_starts_seq, beat_i.valid && !beat_i.opcode && !in_seq && beat_i.rx_byte == CH_ESC, phase_q == PH_ESC, "escape byte did not open a sequence")
endmodule

// ===== hw/rtl/tked_out_reg.sv =====
// Result register of the key escape decoder: holds one key beat until taken.
// Depends on tked_pkg and tked_key_if.
`timescale 1ns / 1ps

module tked_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tked_pkg::result_t result_i,
  output logic              advance_o,
  tked_key_if.source        key_out_o
);
  import tked_pkg::*;

  logic            valid_q, valid_d;
  logic [KeyW-1:0] key_q;

  assign advance_o = !valid_q || key_out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = result_i.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && result_i.emit) begin
      key_q <= result_i.key_code;
    end
  end

  assign key_out_o.valid    = valid_q;
  assign key_out_o.key_code = key_q;
endmodule

// ===== hw/rtl/terminal_key_escape_decoder.sv =====
// Top level of the terminal key escape decoder.
// Depends on tked_pkg, tked_byte_if, tked_key_if, tked_in_reg, tked_parse, tked_out_reg.
//
//   port        dir  beat contents
//   byte_in_i   in   opcode (0 byte, 1 timeout tick), rx_byte[7:0]
//   key_out_o   out  key_code[8:0]
//
// One beat per cycle while keys are taken; a key crosses the input and result registers.
// Input register, parser state and result register pass one beat a cycle unless stalled.
// Reset clears the parse phase to idle, the held digit and both valid flags.
// A stalled result holds the pipe; an empty input register still takes a beat.
`timescale 1ns / 1ps

module terminal_key_escape_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  tked_byte_if.sink  byte_in_i,
  tked_key_if.source key_out_o
);
  import tked_pkg::*;

  beat_t   beat_q;
  beat_t   beat_fire;
  result_t result;
  logic    advance;

  tked_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_in_i (byte_in_i),
    .advance_i (advance),
    .beat_o    (beat_q)
  );

  always_comb begin
    beat_fire       = beat_q;
    beat_fire.valid = beat_q.valid && advance;
  end

  tked_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .beat_i   (beat_fire),
    .result_o (result)
  );

  tked_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .result_i  (result),
    .advance_o (advance),
    .key_out_o (key_out_o)
  );
endmodule
